### src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mcdf_pkg.sv
package mcdf_pkg;

   localparam int FRAME_BITS  = 20;
   localparam int CNT_W       = $clog2(FRAME_BITS + 1);
   localparam int TICK_W      = 24;
   localparam int VALUE_W     = 9;
   localparam int KEY_W       = 8;
   localparam int VALUE_SHIFT = 11;
   localparam logic [31:0] FRAME_SYNC = 32'd514;  // 257 << 1

   localparam logic [KEY_W-1:0] KEY_UP         = 8'h75;  // u
   localparam logic [KEY_W-1:0] KEY_DOWN       = 8'h64;  // d
   localparam logic [KEY_W-1:0] KEY_SEND       = 8'h73;  // s
   localparam logic [KEY_W-1:0] KEY_ON         = 8'h6f;  // o
   localparam logic [KEY_W-1:0] KEY_RELEASE    = 8'h72;  // r
   localparam logic [KEY_W-1:0] KEY_REBOOT     = 8'h62;  // b
   localparam logic [KEY_W-1:0] KEY_HELP       = 8'h68;  // h
   localparam logic [KEY_W-1:0] KEY_ESC        = 8'h1b;
   localparam logic [KEY_W-1:0] KEY_BRACKET    = 8'h5b;  // [
   localparam logic [KEY_W-1:0] KEY_ARROW_UP   = 8'h41;  // A
   localparam logic [KEY_W-1:0] KEY_ARROW_DOWN = 8'h42;  // B

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTION_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_ADDR   = 3'd4;

   localparam logic [TICK_W-1:0] ACTION_TICKS_RST = 24'd9615;
   localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 24'd96154;

   typedef struct packed {
      logic [TICK_W-1:0] action_ticks;
      logic [TICK_W-1:0] display_hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic               action;
      logic [KEY_W-1:0]   key_first;
      logic [KEY_W-1:0]   key_second;
      logic [KEY_W-1:0]   key_third;
      logic [VALUE_W-1:0] display_value;
   } item_type;

   typedef struct packed {
      logic up_drive;
      logic down_drive;
      logic activity_led;
      logic display_enable;
      logic serial_line;
      logic serial_busy;
      logic reboot_request;
   } result_type;

   typedef struct packed {
      logic                  up_level;
      logic                  down_level;
      logic                  led_level;
      logic                  action_armed;
      logic [TICK_W-1:0]     action_left;
      logic                  display_on;
      logic [TICK_W-1:0]     display_left;
      logic [FRAME_BITS-1:0] frame_word;
      logic [FRAME_BITS-1:0] shift_word;
      logic [CNT_W-1:0]      bits_left;
      logic                  shifting;
      logic                  line_level;
   } state_type;

endpackage

### src/motor_command_and_display_frame_ctrl_top.sv
// Motor command and display frame controller.
//
// Input channel (req_*): one transaction is either a bit-period tick
// (req_action = 0) or a command of up to three key bytes plus a display
// value (req_action = 1). Result channel (rsp_*): exactly one transaction
// per input transaction, in order, carrying the drive, LED, display and
// serial line levels after that item plus a one-item reboot pulse.
// CSR port: APB-style, action_ticks at 0x0, display_hold_ticks at 0x4 (24 bits
// each); the user writes them only while the block is idle, not enforced here.
//
// The accepted item is held in the input register and is loaded into the
// result register once that register is free.
// Throughput is one transaction per cycle while rsp_ready is high, set by
// the single state update per item.
// While rsp_ready is low the result register holds and one more item may
// wait in the input register; req_ready then drops until the result drains.
// Synchronous reset empties both registers and returns all state and the
// timeout registers to their defaults.
module motor_command_and_display_frame_ctrl_top
   import mcdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [KEY_W-1:0]      req_key_first,
   input  logic [KEY_W-1:0]      req_key_second,
   input  logic [KEY_W-1:0]      req_key_third,
   input  logic [VALUE_W-1:0]    req_display_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_up_drive,
   output logic                  rsp_down_drive,
   output logic                  rsp_activity_led,
   output logic                  rsp_display_enable,
   output logic                  rsp_serial_line,
   output logic                  rsp_serial_busy,
   output logic                  rsp_reboot_request,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff;
   logic       item_valid_in;
   result_type result;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       advance;
   logic       req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_fire) begin
         item_in.action        = req_action;
         item_in.key_first     = req_key_first;
         item_in.key_second    = req_key_second;
         item_in.key_third     = req_key_third;
         item_in.display_value = req_display_value;
         item_valid_in         = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   mcdf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mcdf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_up_drive       = rsp_ff.up_drive;
   assign rsp_down_drive     = rsp_ff.down_drive;
   assign rsp_activity_led   = rsp_ff.activity_led;
   assign rsp_display_enable = rsp_ff.display_enable;
   assign rsp_serial_line    = rsp_ff.serial_line;
   assign rsp_serial_busy    = rsp_ff.serial_busy;
   assign rsp_reboot_request = rsp_ff.reboot_request;

endmodule

### src/mcdf_csr.sv
module mcdf_csr
   import mcdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr)
            CSR_ACTION_ADDR: begin
               cfg_in.action_ticks = csr_pwdata[TICK_W-1:0];
            end
            CSR_HOLD_ADDR: begin
               cfg_in.display_hold_ticks = csr_pwdata[TICK_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_ACTION_ADDR: begin
            csr_prdata = 32'(cfg_ff.action_ticks);
         end
         CSR_HOLD_ADDR: begin
            csr_prdata = 32'(cfg_ff.display_hold_ticks);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.action_ticks       <= ACTION_TICKS_RST;
         cfg_ff.display_hold_ticks <= HOLD_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/mcdf_core.sv
module mcdf_core
   import mcdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   state_type state_ff;
   state_type state_in;
   logic      reboot;

   function automatic state_type send_bit(state_type s);
      state_type r;
      r            = s;
      r.line_level = s.shift_word[0];
      r.shift_word = s.shift_word >> 1;
      r.bits_left  = s.bits_left - 1'b1;
      r.shifting   = 1'b1;
      if (r.bits_left == '0) begin
         r.bits_left  = CNT_W'(FRAME_BITS);
         r.shift_word = s.frame_word;
         if (!s.display_on) begin
            r.shifting = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic state_type start_motion(state_type s, logic up,
                                              logic [TICK_W-1:0] ticks);
      state_type r;
      r = s;
      if (up) begin
         r.up_level = 1'b1;
      end else begin
         r.down_level = 1'b1;
      end
      r.led_level    = 1'b1;
      r.action_armed = 1'b1;
      r.action_left  = ticks;
      return r;
   endfunction

   function automatic state_type halt_motion(state_type s);
      state_type r;
      r              = s;
      r.up_level     = 1'b0;
      r.down_level   = 1'b0;
      r.led_level    = 1'b0;
      r.action_armed = 1'b0;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      reboot   = 1'b0;
      if (!item.action) begin
         if (state_in.action_armed) begin
            if (state_in.action_left <= TICK_W'(1)) begin
               state_in.action_left = '0;
               state_in             = halt_motion(state_in);
            end else begin
               state_in.action_left = state_in.action_left - 1'b1;
            end
         end
         if (state_in.display_on) begin
            if (state_in.display_left <= TICK_W'(1)) begin
               state_in.display_left = '0;
               state_in.display_on   = 1'b0;
            end else begin
               state_in.display_left = state_in.display_left - 1'b1;
            end
         end
         if (state_in.shifting) begin
            state_in = send_bit(state_in);
         end
      end else begin
         unique case (item.key_first)
            KEY_UP: begin
               state_in = start_motion(state_in, 1'b1, cfg.action_ticks);
            end
            KEY_DOWN: begin
               state_in = start_motion(state_in, 1'b0, cfg.action_ticks);
            end
            KEY_SEND: begin
               state_in.frame_word   = FRAME_BITS'((32'(item.display_value) << VALUE_SHIFT)
                                                   | FRAME_SYNC);
               state_in.display_on   = 1'b1;
               state_in.display_left = cfg.display_hold_ticks;
               state_in.shift_word   = state_in.frame_word;
               state_in              = send_bit(state_in);
            end
            KEY_ON: begin
               state_in.display_on   = 1'b1;
               state_in.display_left = cfg.display_hold_ticks;
            end
            KEY_RELEASE: begin
               state_in.display_on = 1'b0;
            end
            KEY_REBOOT: begin
               reboot = 1'b1;
            end
            KEY_HELP: begin
               state_in = state_ff;
            end
            KEY_ESC: begin
               if (item.key_second == KEY_BRACKET) begin
                  if (item.key_third == KEY_ARROW_UP) begin
                     state_in = start_motion(state_in, 1'b1, cfg.action_ticks);
                  end else if (item.key_third == KEY_ARROW_DOWN) begin
                     state_in = start_motion(state_in, 1'b0, cfg.action_ticks);
                  end
               end
            end
            default: begin
               state_in = halt_motion(state_in);
            end
         endcase
      end
   end

   always_comb begin
      result.up_drive       = state_in.up_level;
      result.down_drive     = state_in.down_level;
      result.activity_led   = state_in.led_level;
      result.display_enable = state_in.display_on;
      result.serial_line    = state_in.line_level;
      result.serial_busy    = state_in.shifting;
      result.reboot_request = reboot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.up_level     <= 1'b0;
         state_ff.down_level   <= 1'b0;
         state_ff.led_level    <= 1'b0;
         state_ff.action_armed <= 1'b0;
         state_ff.action_left  <= '0;
         state_ff.display_on   <= 1'b0;
         state_ff.display_left <= '0;
         state_ff.frame_word   <= '0;
         state_ff.shift_word   <= '0;
         state_ff.bits_left    <= CNT_W'(FRAME_BITS);
         state_ff.shifting     <= 1'b0;
         state_ff.line_level   <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

### src/mcdf_checker.sv
`include "assert_macros.svh"

module mcdf_checker
   import mcdf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_up_drive,
   input logic rsp_down_drive,
   input logic rsp_activity_led,
   input logic rsp_display_enable,
   input logic rsp_serial_line,
   input logic rsp_serial_busy,
   input logic rsp_reboot_request
);

   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

   `ASSERT_CLK(a_led_tracks_drives, clock, reset, rsp_valid |-> (rsp_activity_led == (rsp_up_drive || rsp_down_drive)), "activity LED disagrees with drives")

   `ASSERT_CLK(a_drain_frees_input, clock, reset, rsp_ready |-> req_ready, "input stalled while result side drains")

   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_up_drive) && $stable(rsp_down_drive) && $stable(rsp_activity_led) && $stable(rsp_display_enable) && $stable(rsp_serial_line) && $stable(rsp_serial_busy) && $stable(rsp_reboot_request)), "stalled result changed")

endmodule

bind motor_command_and_display_frame_ctrl_top mcdf_checker u_mcdf_checker (.*);
